>>> rtl/fps_pkg.sv
`timescale 1ns / 1ps

package fps_pkg;

    // default storage depth of the tree
    localparam int unsigned MAX_POSITIONS_DEF = 1024;

    // field widths
    localparam int unsigned SIZE_W   = 11;
    localparam int unsigned IDX_W    = 11;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // request kinds carried in tuser
    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

endpackage

>>> rtl/fenwick_prefix_sum_table.sv
// Binary indexed (Fenwick) prefix-sum table over positions 1..size_in_use. An add request
// (tuser = 0) adds the signed delta at the index, climbing index + lowest set bit while the
// node stays within the effective size (size_in_use saturated to MAX_POSITIONS), then returns
// the wrapped 32-bit sum of positions 1..index, the index saturated to the effective size; a
// delta of zero is a plain query and index zero adds nothing and returns 0. A clear request
// (tuser = 1) zeroes every node and returns 0. All nodes sit in one memory with one write
// port and one registered read port; each walk step is a read, and on the upward walk the
// write-back of one node shares the cycle with the read of the next. An add request walks
// up the tree, then down it, then loads its result; an index-zero request goes straight to
// its result, and a clear request first sweeps every node. The next request can be taken
// in the cycle after the result is loaded. After reset the memory is swept to zero with
// s_axis_tready low; configuration writes are taken at any time. One request is in work
// at a time; the next is taken while a result still waits in the output register.
`timescale 1ns / 1ps

module fenwick_prefix_sum_table #(
    parameter int unsigned MAX_POSITIONS = fps_pkg::MAX_POSITIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // size_in_use register
    input  logic                                i_cfg_we,
    input  logic [fps_pkg::SIZE_W-1:0]          i_cfg_wdata,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [10:0] index, [42:11] delta
    input  logic                                s_axis_tuser,  // [0] cmd
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [31:0] prefix_sum
);

    // memory address width and internal position width (room for the climb overshoot)
    localparam int unsigned AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int unsigned PW = (AW + 1 > fps_pkg::IDX_W + 1) ? AW + 1 : fps_pkg::IDX_W + 1;
    localparam int unsigned DW = fps_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UP,
        S_DOWN,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [fps_pkg::SIZE_W-1:0] r_size_in_use;
    logic [AW-1:0]              r_clr_cnt;
    logic                       r_clr_reply;   // sweep was asked for, so it owes a result
    logic [PW-1:0]              r_pos;         // next node of the upward walk
    logic [PW-1:0]              r_wpos;        // node whose read is in flight on the way up
    logic [PW-1:0]              r_qpos;        // next node of the downward walk
    logic [PW-1:0]              r_limit;
    logic                       r_pend;        // a read was issued last cycle
    logic [DW-1:0]              r_delta;
    logic [DW-1:0]              r_acc;
    logic                       r_m_valid;
    logic [DW-1:0]              r_m_data;

    // node storage, node p lives at entry p-1
    logic [DW-1:0]              r_mem [MAX_POSITIONS];
    logic [DW-1:0]              r_rdata;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [DW-1:0]              mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;

    logic [PW-1:0]              eff_size;
    logic [PW-1:0]              in_index;
    logic [PW-1:0]              pos_m1;
    logic [PW-1:0]              wpos_m1;
    logic [PW-1:0]              qpos_m1;
    logic                       up_in_range;
    logic                       in_accept;
    logic                       out_accept;
    logic                       res_load;

    // effective size is the register saturated to the storage depth
    always_comb begin
        if (PW'(r_size_in_use) > PW'(MAX_POSITIONS)) begin
            eff_size = PW'(MAX_POSITIONS);
        end else begin
            eff_size = PW'(r_size_in_use);
        end
    end

    assign in_index    = PW'(s_axis_tdata[fps_pkg::IDX_W-1:0]);
    assign pos_m1      = r_pos - PW'(1);
    assign wpos_m1     = r_wpos - PW'(1);
    assign qpos_m1     = r_qpos - PW'(1);
    assign up_in_range = (r_pos != '0) && (r_pos <= r_limit);
    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign out_accept  = r_m_valid && m_axis_tready;
    // result register takes a new value when it is empty or being drained
    assign res_load    = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // memory port control; on the way up the write-back of one node and the read of the
    // next always hit different nodes, and the downward walk starts only after the last write
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_cnt;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = pos_m1[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_UP: begin
                mem_we    = r_pend;
                mem_waddr = wpos_m1[AW-1:0];
                mem_wdata = r_rdata + r_delta;
                mem_re    = up_in_range;
            end
            S_DOWN: begin
                mem_re    = (r_qpos != '0);
                mem_raddr = qpos_m1[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_in_use <= fps_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size_in_use <= i_cfg_wdata;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
            r_pend      <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (res_load) begin
                r_m_valid <= 1'b1;
            end else if (out_accept) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_cnt == AW'(MAX_POSITIONS - 1)) begin
                        r_clr_cnt <= '0;
                        r_state   <= r_clr_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_cnt <= r_clr_cnt + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_acc   <= '0;
                        r_pend  <= 1'b0;
                        r_delta <= s_axis_tdata[fps_pkg::IDX_W +: DW];
                        r_pos   <= in_index;
                        r_limit <= eff_size;
                        r_qpos  <= (in_index > eff_size) ? eff_size : in_index;
                        priority if (s_axis_tuser == fps_pkg::CMD_CLEAR) begin
                            r_clr_reply <= 1'b1;
                            r_state     <= S_CLEAR;
                        end else if (in_index == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_UP;
                        end
                    end
                end
                S_UP: begin
                    // climb: index plus its lowest set bit
                    if (up_in_range) begin
                        r_wpos <= r_pos;
                        r_pos  <= r_pos + (r_pos & (~r_pos + PW'(1)));
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_DOWN;
                    end
                end
                S_DOWN: begin
                    // descend: clear the lowest set bit, one read per node
                    if (r_pend) begin
                        r_acc <= r_acc + r_rdata;
                    end
                    if (r_qpos != '0) begin
                        r_qpos <= r_qpos & qpos_m1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (res_load) begin
                        r_m_data    <= r_acc;
                        r_clr_reply <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/fps_chk.sv
`timescale 1ns / 1ps

module fps_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [fps_pkg::SIZE_W-1:0]       i_cfg_wdata,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [fps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // memory sweep after reset holds off requests
    a_sweep_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("request taken during reset sweep");

    // no result pending right after reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one request in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in work");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind fenwick_prefix_sum_table fps_chk u_fps_chk (.*);

>>> tb/fenwick_prefix_sum_table_tb.sv
`timescale 1ns / 1ps

module fenwick_prefix_sum_table_tb;

    localparam int unsigned MAX_POS      = fps_pkg::MAX_POSITIONS_DEF;
    localparam int unsigned SIZE_W       = fps_pkg::SIZE_W;
    localparam int unsigned IDX_W        = fps_pkg::IDX_W;
    localparam int unsigned DATA_W       = fps_pkg::DATA_W;
    localparam int unsigned IN_TDATA_W   = fps_pkg::IN_TDATA_W;
    localparam int unsigned OUT_TDATA_W  = fps_pkg::OUT_TDATA_W;
    localparam int unsigned PAD_W        = IN_TDATA_W - DATA_W - IDX_W;
    localparam int unsigned NUM_DIRECTED = 27;
    localparam int unsigned NUM_PHASES   = 14;
    localparam int unsigned PHASE_ITEMS  = 130;

    // directed rows either send a request or rewrite the size register
    typedef enum logic {
        ROW_REQUEST = 1'b0,
        ROW_SIZE    = 1'b1
    } t_row_kind;

    // for a size row the new size travels in idx
    typedef struct {
        t_row_kind          kind;
        fps_pkg::t_cmd      cmd;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  delta;
        bit                 known;
        logic [DATA_W-1:0]  sum;
    } t_row;

    typedef struct {
        fps_pkg::t_cmd      cmd;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  sum;
    } t_pending_sum;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [SIZE_W-1:0]       i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;    // [10:0] index, [42:11] delta
    logic                    s_axis_tuser = 1'b0;  // [0] cmd
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;         // [31:0] prefix_sum

    // mirror of the tree and of the size register
    logic [DATA_W-1:0]       mirror_nodes [0:MAX_POS-1];
    logic [SIZE_W-1:0]       mirror_size = fps_pkg::SIZE_RESET;

    t_pending_sum            expected_sums [$];
    t_row                    directed_rows [0:NUM_DIRECTED-1];
    int unsigned             mismatch_count = 0;
    int unsigned             tready_hold = 0;
    bit                      calm_phase = 1'b0;

    fenwick_prefix_sum_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // generous bound on the length of the whole run
    initial begin
        #40_000_000;
        $display("** fenwick_prefix_sum_table: FAILED **");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // mostly back to back, sometimes a short gap, now and then a long one; none in a calm phase
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm_phase || r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    // applies one request to the mirror and returns the prefix sum it yields
    function automatic logic [DATA_W-1:0] predict_prefix_sum(input fps_pkg::t_cmd cmd,
                                                             input logic [IDX_W-1:0] idx,
                                                             input logic [DATA_W-1:0] delta);
        logic [11:0]       lim;
        logic [11:0]       p;
        logic [DATA_W-1:0] acc;
        lim = (mirror_size > MAX_POS) ? 12'(MAX_POS) : {1'b0, mirror_size};
        acc = '0;
        if (cmd == fps_pkg::CMD_CLEAR) begin
            foreach (mirror_nodes[k]) mirror_nodes[k] = '0;
        end else if (idx != '0) begin
            // upward walk, only while the node is in use
            p = {1'b0, idx};
            while (p >= 12'd1 && p <= lim) begin
                mirror_nodes[p - 12'd1] = mirror_nodes[p - 12'd1] + delta;
                p = p + (p & (-p));
            end
            // downward walk over the saturated index
            p = ({1'b0, idx} > lim) ? lim : {1'b0, idx};
            while (p != 12'd0) begin
                acc = acc + mirror_nodes[p - 12'd1];
                p = p & (p - 12'd1);
            end
        end
        return acc;
    endfunction

    task automatic send_request(input fps_pkg::t_cmd cmd, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] delta,
                                input logic [DATA_W-1:0] sum);
        int unsigned gap;
        gap = pick_gap();
        // tvalid stays high across back-to-back requests
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{PAD_W{1'b0}}, delta, idx};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expected_sums.push_back('{cmd, idx, sum});
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_sums.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] value);
        wait_all_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mirror_size = value;
    endtask

    // result side: check on every handshake, then pick the next tready
    always @(posedge i_clk) begin
        t_pending_sum head;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (expected_sums.size() == 0) begin
                flag_mismatch($sformatf("result %h with no request outstanding", m_axis_tdata));
            end else begin
                head = expected_sums.pop_front();
                if (m_axis_tdata[DATA_W-1:0] !== head.sum)
                    flag_mismatch($sformatf("%s idx %0d: prefix_sum %h, expected %h",
                                            head.cmd.name(), head.idx,
                                            m_axis_tdata[DATA_W-1:0], head.sum));
            end
        end
        if (tready_hold != 0) begin
            tready_hold--;
            m_axis_tready <= 1'b0;
        end else if (!calm_phase && $urandom_range(99) < 20) begin
            tready_hold = pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        fps_pkg::t_cmd      rcmd;
        logic [IDX_W-1:0]   ridx;
        logic [DATA_W-1:0]  rdelta;
        logic [DATA_W-1:0]  rsum;
        logic [SIZE_W-1:0]  rsize;
        int unsigned        lim;
        int unsigned        r;

        foreach (mirror_nodes[k]) mirror_nodes[k] = '0;

        // known sums only where they follow directly from reset, clear, zero size or index zero
        directed_rows = '{
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1,    32'h0000_0000, 1'b1, 32'h0000_0000},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd0,    32'h0000_0005, 1'b1, 32'h0000_0000},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1,    32'h0000_0001, 1'b1, 32'h8000_0000},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1024, 32'h8000_0000, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd2047, 32'h1234_5678, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd512,  32'hFFFF_FFFF, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'h2AA,  32'hAAAA_AAAA, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'h555,  32'h5555_5555, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd3,    32'hFFFF_FFFD, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd8,    32'h0000_0100, 1'b0, 32'h0},
            // lowered size hides node 8, queries saturate to 5
            '{ROW_SIZE,    fps_pkg::CMD_ADD,   11'd5,    32'h0,         1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd8,    32'h0000_0000, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd5,    32'h0000_0009, 1'b0, 32'h0},
            // no position in use
            '{ROW_SIZE,    fps_pkg::CMD_ADD,   11'd0,    32'h0,         1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd4,    32'h0000_0077, 1'b1, 32'h0000_0000},
            // size above storage saturates
            '{ROW_SIZE,    fps_pkg::CMD_ADD,   11'd2047, 32'h0,         1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1024, 32'h0000_0000, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1023, 32'h0000_0001, 1'b0, 32'h0},
            '{ROW_SIZE,    fps_pkg::CMD_ADD,   11'd1,    32'h0,         1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1,    32'h0000_0002, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd2,    32'h0000_0003, 1'b0, 32'h0},
            // raised again, node 8 visible once more
            '{ROW_SIZE,    fps_pkg::CMD_ADD,   11'd1024, 32'h0,         1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd8,    32'h0000_0000, 1'b0, 32'h0},
            '{ROW_REQUEST, fps_pkg::CMD_CLEAR, 11'd1024, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1024, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{ROW_REQUEST, fps_pkg::CMD_ADD,   11'd1,    32'h0000_0000, 1'b1, 32'h0000_0000}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_SIZE) begin
                set_size(directed_rows[k].idx);
            end else begin
                rsum = predict_prefix_sum(directed_rows[k].cmd, directed_rows[k].idx,
                                          directed_rows[k].delta);
                if (directed_rows[k].known)
                    rsum = directed_rows[k].sum;
                send_request(directed_rows[k].cmd, directed_rows[k].idx,
                             directed_rows[k].delta, rsum);
            end
        end

        // random phases, each under its own size setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: rsize = 11'd1;
                1: rsize = 11'd2;
                2: rsize = 11'd1024;
                3: rsize = 11'd0;
                4: rsize = 11'd2047;
                5: rsize = 11'd1023;
                default: begin
                    r = $urandom_range(99);
                    if (r < 50)      rsize = SIZE_W'($urandom_range(1, 64));
                    else if (r < 80) rsize = SIZE_W'($urandom_range(1, 1024));
                    else             rsize = SIZE_W'($urandom_range(0, 2047));
                end
            endcase
            set_size(rsize);
            calm_phase = (ph % 4 == 3);
            lim = (mirror_size > MAX_POS) ? MAX_POS : mirror_size;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rcmd = ($urandom_range(999) < 15) ? fps_pkg::CMD_CLEAR : fps_pkg::CMD_ADD;
                // indexes mostly inside the live range, some beyond it and some zero
                r = $urandom_range(99);
                if (r < 5)
                    ridx = '0;
                else if (r < 18 || lim == 0)
                    ridx = IDX_W'($urandom_range(0, 2047));
                else if (r < 28)
                    ridx = IDX_W'(lim);
                else
                    ridx = IDX_W'($urandom_range(1, lim));
                r = $urandom_range(99);
                if (r < 20)
                    rdelta = '0;
                else if (r < 60)
                    rdelta = DATA_W'($urandom_range(16)) - 32'd8;
                else if (r < 90)
                    rdelta = $urandom;
                else
                    case ($urandom_range(3))
                        0: rdelta = 32'h8000_0000;
                        1: rdelta = 32'h7FFF_FFFF;
                        2: rdelta = 32'hFFFF_FFFF;
                        default: rdelta = 32'h0000_0001;
                    endcase
                rsum = predict_prefix_sum(rcmd, ridx, rdelta);
                send_request(rcmd, ridx, rdelta, rsum);
                // occasional full drain in the middle of a phase
                if ($urandom_range(199) == 0)
                    wait_all_results();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** fenwick_prefix_sum_table: PASSED **");
        else
            $display("** fenwick_prefix_sum_table: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/fps_pkg.sv
rtl/fenwick_prefix_sum_table.sv
rtl/fps_chk.sv
tb/fenwick_prefix_sum_table_tb.sv
